>>> hdl/sstl_pkg.sv
// Shared types and constants for the sorted timer list.
`timescale 1ns / 1ps
package sstl_pkg;

   localparam int MODE_W     = 3;
   localparam int TIDX_W     = 5;
   localparam int QUEUE_W    = 4;
   localparam int VALUE_W    = 32;
   localparam int DEADLINE_W = 32;
   localparam int KIND_W     = 2;
   localparam int RUN_W      = 6;

   localparam logic [DEADLINE_W-1:0] DEADLINE_NEVER = 32'hffff_ffff;
   localparam logic [RUN_W-1:0]      RUN_MAX        = 6'd32;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK  = 3'd0,
      MODE_ALLOC = 3'd1,
      MODE_FREE  = 3'd2,
      MODE_BIND  = 3'd3,
      MODE_ARM   = 3'd4
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_EXPIRY = 2'd1,
      KIND_ACK    = 2'd2
   } reply_type;

   typedef enum logic [2:0] {
      FL_NONE,
      FL_ALLOC,
      FL_FREE,
      FL_ARM,
      FL_DISARM
   } flag_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ALLOC,
      ST_TICK,
      ST_WALK,
      ST_LINK,
      ST_RESP
   } state_type;

endpackage

>>> hdl/sstl_if.sv
// Request and response channel interfaces for the sorted timer list.
`timescale 1ns / 1ps
interface sstl_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [4:0]  timer_index;
   logic [3:0]  queue_id;
   logic [31:0] event_value;
   logic [31:0] delay_ticks;

   modport source (output valid, mode, timer_index, queue_id, event_value, delay_ticks,
                   input ready);
   modport sink (input valid, mode, timer_index, queue_id, event_value, delay_ticks,
                 output ready);
endinterface

interface sstl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reply_kind;
   logic [4:0]  entry_index;
   logic        alloc_ok;
   logic [3:0]  dest_queue;
   logic [31:0] expiry_data;
   logic        last_of_run;

   modport source (output valid, reply_kind, entry_index, alloc_ok, dest_queue,
                   expiry_data, last_of_run, input ready);
   modport sink (input valid, reply_kind, entry_index, alloc_ok, dest_queue,
                 expiry_data, last_of_run, output ready);
endinterface

>>> hdl/sorted_software_timer_list.sv
// Sorted timer list: timer table in two RAMs, list walker and response register.
// Free and bind: the response follows the request through EXEC and RESP; allocate: the
// response waits for the one-entry-per-cycle scan of the usage flags in ALLOC.
// Arm: at the head the response follows EXEC, else the walk passes one entry per cycle.
// Tick: one expiry per cycle from TICK unless the output stalls; one request at a time.
// Reset is synchronous: the list holds only the sentinel, all entries but entry 0 are free.
`timescale 1ns / 1ps
module sorted_software_timer_list #(
   parameter int NUM_TIMERS = 32
) (
   input logic         clock,
   input logic         reset,
   sstl_req_if.sink    req_ch,
   sstl_rsp_if.source  rsp_ch
);
   import sstl_pkg::*;

   localparam int IW = $clog2(NUM_TIMERS);
   localparam int MW = DEADLINE_W + IW;
   localparam int DW = QUEUE_W + VALUE_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

   state_type state_ff, state_in;

   logic [DEADLINE_W-1:0] tick_ff, tick_in;
   logic [DEADLINE_W-1:0] earliest_ff, earliest_in;
   logic [IW-1:0]         head_ff, head_in;
   mode_type              mode_ff, mode_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  usable_ff, usable_in;
   logic [QUEUE_W-1:0]    queue_ff, queue_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [DEADLINE_W-1:0] dl_ff, dl_in;
   logic [IW-1:0]         prev_ff, prev_in;
   logic [DEADLINE_W-1:0] prev_dl_ff, prev_dl_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [IW-1:0]         scan_ff, scan_in;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [IW-1:0]         pend_idx_ff, pend_idx_in;
   logic [QUEUE_W-1:0]    pend_queue_ff, pend_queue_in;
   logic [VALUE_W-1:0]    pend_value_ff, pend_value_in;
   reply_type             res_kind_ff, res_kind_in;
   logic [IW-1:0]         res_idx_ff, res_idx_in;
   logic                  res_ok_ff, res_ok_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   reply_type             rsp_kind_ff, rsp_kind_in;
   logic [IW-1:0]         rsp_idx_ff, rsp_idx_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [QUEUE_W-1:0]    rsp_queue_ff, rsp_queue_in;
   logic [VALUE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic          meta_we, meta_re, data_we, data_re;
   logic [IW-1:0] meta_waddr, meta_raddr, data_waddr, data_raddr;
   logic [MW-1:0] meta_wdata, meta_rdata;
   logic [DW-1:0] data_wdata, data_rdata;

   flag_op_type   flag_op;
   logic [IW-1:0] flag_idx;
   logic          flag_busy, flag_armed;

   logic                  req_accept, out_free;
   logic [IW-1:0]         sel_idx;
   logic [DEADLINE_W-1:0] rd_dl;
   logic [IW-1:0]         rd_link;
   logic                  tick_skip, tick_due, tick_stall;
   logic                  walk_stop, arm_ok, arm_head, alloc_hit, alloc_end;

   sstl_ram #(.WIDTH(MW), .DEPTH(NUM_TIMERS)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (meta_re),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   sstl_ram #(.WIDTH(DW), .DEPTH(NUM_TIMERS)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_waddr),
      .wr_data (data_wdata),
      .rd_en   (data_re),
      .rd_addr (data_raddr),
      .rd_data (data_rdata)
   );

   sstl_flags #(.NUM_TIMERS(NUM_TIMERS)) u_flags (
      .clock     (clock),
      .reset     (reset),
      .op        (flag_op),
      .op_idx    (flag_idx),
      .busy_idx  (scan_ff),
      .busy      (flag_busy),
      .armed_idx (idx_ff),
      .armed     (flag_armed)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid & req_ch.ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;

   // The sentinel is never written, so its deadline is supplied here.
   assign sel_idx    = (state_ff == ST_TICK) ? head_ff : cur_ff;
   assign rd_dl      = (sel_idx == '0) ? DEADLINE_NEVER : meta_rdata[MW-1:IW];
   assign rd_link    = meta_rdata[IW-1:0];

   assign tick_skip  = (earliest_ff > tick_ff);
   assign tick_due   = (head_ff != '0) && (rd_dl <= tick_ff) && (run_ff < RUN_MAX);
   assign tick_stall = pend_valid_ff & ~out_free;
   assign walk_stop  = (cur_ff == '0) || (dl_ff <= rd_dl);
   assign arm_ok     = usable_ff & ~flag_armed;
   assign arm_head   = (dl_ff <= earliest_ff);
   assign alloc_hit  = ~flag_busy;
   assign alloc_end  = (scan_ff == LAST_IDX);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (mode_ff)
               MODE_TICK:  state_in = tick_skip ? ST_IDLE : ST_TICK;
               MODE_ALLOC: state_in = ST_ALLOC;
               MODE_ARM:   state_in = (arm_ok && !arm_head) ? ST_WALK : ST_RESP;
               default:    state_in = ST_RESP;
            endcase
         end
         ST_ALLOC: begin
            if (alloc_hit || alloc_end) state_in = ST_RESP;
         end
         ST_TICK: begin
            if (!tick_stall && !tick_due) state_in = ST_IDLE;
         end
         ST_WALK: begin
            if (walk_stop) state_in = ST_LINK;
         end
         ST_LINK: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      tick_in       = tick_ff;
      earliest_in   = earliest_ff;
      head_in       = head_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      usable_in     = usable_ff;
      queue_in      = queue_ff;
      value_in      = value_ff;
      dl_in         = dl_ff;
      prev_in       = prev_ff;
      prev_dl_in    = prev_dl_ff;
      cur_in        = cur_ff;
      scan_in       = scan_ff;
      run_in        = run_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_queue_in = pend_queue_ff;
      pend_value_in = pend_value_ff;
      res_kind_in   = res_kind_ff;
      res_idx_in    = res_idx_ff;
      res_ok_in     = res_ok_ff;

      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_queue_in  = rsp_queue_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      meta_we    = 1'b0;
      meta_waddr = idx_ff;
      meta_wdata = {dl_ff, cur_ff};
      meta_re    = 1'b0;
      meta_raddr = head_ff;
      data_we    = 1'b0;
      data_waddr = idx_ff;
      data_wdata = {queue_ff, value_ff};
      data_re    = 1'b0;
      data_raddr = head_ff;
      flag_op    = FL_NONE;
      flag_idx   = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in       = mode_type'(req_ch.mode);
               idx_in        = IW'(req_ch.timer_index);
               usable_in     = ({2'b00, req_ch.timer_index} < 7'(NUM_TIMERS)) &&
                               (req_ch.timer_index != '0);
               queue_in      = req_ch.queue_id;
               value_in      = req_ch.event_value;
               dl_in         = tick_ff + req_ch.delay_ticks;
               scan_in       = '0;
               run_in        = '0;
               pend_valid_in = 1'b0;
               res_kind_in   = KIND_ACK;
               res_idx_in    = '0;
               res_ok_in     = 1'b0;
               if (mode_type'(req_ch.mode) == MODE_TICK) tick_in = tick_ff + 32'd1;
            end
         end
         ST_EXEC: begin
            case (mode_ff)
               MODE_TICK: begin
                  if (!tick_skip) begin
                     meta_re = 1'b1;
                     data_re = 1'b1;
                  end
               end
               MODE_FREE: begin
                  if (arm_ok) flag_op = FL_FREE;
               end
               MODE_BIND: begin
                  if (usable_ff) data_we = 1'b1;
               end
               MODE_ARM: begin
                  if (arm_ok) begin
                     flag_op = FL_ARM;
                     if (arm_head) begin
                        meta_we     = 1'b1;
                        meta_wdata  = {dl_ff, head_ff};
                        head_in     = idx_ff;
                        earliest_in = dl_ff;
                     end else begin
                        prev_in    = head_ff;
                        prev_dl_in = earliest_ff;
                        cur_in     = head_ff;
                        meta_re    = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_ALLOC: begin
            flag_idx = scan_ff;
            if (alloc_hit) begin
               flag_op     = FL_ALLOC;
               res_kind_in = KIND_ALLOC;
               res_idx_in  = scan_ff;
               res_ok_in   = 1'b1;
            end else if (alloc_end) begin
               res_kind_in = KIND_ALLOC;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         ST_TICK: begin
            if (!tick_stall) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_EXPIRY;
                  rsp_idx_in   = pend_idx_ff;
                  rsp_ok_in    = 1'b0;
                  rsp_queue_in = pend_queue_ff;
                  rsp_data_in  = pend_value_ff;
                  rsp_last_in  = ~tick_due;
               end
               if (tick_due) begin
                  pend_valid_in = 1'b1;
                  pend_idx_in   = head_ff;
                  pend_queue_in = data_rdata[DW-1:VALUE_W];
                  pend_value_in = data_rdata[VALUE_W-1:0];
                  flag_op       = FL_DISARM;
                  flag_idx      = head_ff;
                  head_in       = rd_link;
                  run_in        = run_ff + RUN_W'(1);
                  meta_re       = 1'b1;
                  meta_raddr    = rd_link;
                  data_re       = 1'b1;
                  data_raddr    = rd_link;
               end else begin
                  pend_valid_in = 1'b0;
                  earliest_in   = rd_dl;
               end
            end
         end
         ST_WALK: begin
            if (walk_stop) begin
               meta_we    = 1'b1;
               meta_waddr = prev_ff;
               meta_wdata = {prev_dl_ff, idx_ff};
            end else begin
               prev_in    = cur_ff;
               prev_dl_in = rd_dl;
               cur_in     = rd_link;
               meta_re    = 1'b1;
               meta_raddr = rd_link;
            end
         end
         ST_LINK: begin
            meta_we = 1'b1;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_idx_in   = res_idx_ff;
               rsp_ok_in    = res_ok_ff;
               rsp_queue_in = '0;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         earliest_ff   <= DEADLINE_NEVER;
         head_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         run_ff        <= '0;
         scan_ff       <= '0;
         mode_ff       <= MODE_TICK;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         earliest_ff   <= earliest_in;
         head_ff       <= head_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         run_ff        <= run_in;
         scan_ff       <= scan_in;
         mode_ff       <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      usable_ff     <= usable_in;
      queue_ff      <= queue_in;
      value_ff      <= value_in;
      dl_ff         <= dl_in;
      prev_ff       <= prev_in;
      prev_dl_ff    <= prev_dl_in;
      cur_ff        <= cur_in;
      pend_idx_ff   <= pend_idx_in;
      pend_queue_ff <= pend_queue_in;
      pend_value_ff <= pend_value_in;
      res_kind_ff   <= res_kind_in;
      res_idx_ff    <= res_idx_in;
      res_ok_ff     <= res_ok_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_queue_ff  <= rsp_queue_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.reply_kind  = rsp_kind_ff;
   assign rsp_ch.entry_index = TIDX_W'(rsp_idx_ff);
   assign rsp_ch.alloc_ok    = rsp_ok_ff;
   assign rsp_ch.dest_queue  = rsp_queue_ff;
   assign rsp_ch.expiry_data = rsp_data_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;

   // The sentinel entry is never written.
   assert property (@(posedge clock) disable iff (reset) meta_we |-> meta_waddr != '0)
      else $error("sentinel entry written");

   // An empty list always reports no pending deadline.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && head_ff == '0) |-> earliest_ff == DEADLINE_NEVER)
      else $error("empty list with a pending deadline");

   // A tick never emits more than the run limit.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TICK |-> run_ff <= RUN_MAX)
      else $error("expiry run too long");

   // No expiry is held back once the request has finished.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RESP) |-> !pend_valid_ff)
      else $error("expiry left pending");
endmodule

>>> hdl/sstl_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module sstl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/sstl_flags.sv
// Per-entry usage and armed flags of the timer table.
`timescale 1ns / 1ps
module sstl_flags #(
   parameter int NUM_TIMERS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sstl_pkg::flag_op_type         op,
   input  logic [$clog2(NUM_TIMERS)-1:0] op_idx,
   input  logic [$clog2(NUM_TIMERS)-1:0] busy_idx,
   output logic                          busy,
   input  logic [$clog2(NUM_TIMERS)-1:0] armed_idx,
   output logic                          armed
);
   import sstl_pkg::*;

   logic [NUM_TIMERS-1:0] busy_ff, busy_in;
   logic [NUM_TIMERS-1:0] armed_ff, armed_in;

   always_comb begin
      busy_in  = busy_ff;
      armed_in = armed_ff;
      case (op)
         FL_ALLOC: begin
            busy_in[op_idx] = 1'b1;
         end
         FL_FREE: begin
            busy_in[op_idx] = 1'b0;
         end
         FL_ARM: begin
            busy_in[op_idx]  = 1'b1;
            armed_in[op_idx] = 1'b1;
         end
         FL_DISARM: begin
            armed_in[op_idx] = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= NUM_TIMERS'(1);
         armed_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         armed_ff <= armed_in;
      end
   end

   assign busy  = busy_ff[busy_idx];
   assign armed = armed_ff[armed_idx];
endmodule

>>> test/sstl_checker.sv
// Checker for the sorted timer list: tracks the timer table and compares every response.
`timescale 1ns / 1ps
module sstl_checker (
   input  logic   clock,
   input  logic   reset,
   sstl_req_if    req_ch,
   sstl_rsp_if    rsp_ch,
   output int     error_count,
   output int     pending_count
);
   import sstl_pkg::*;

   localparam int NUM_TIMERS = 32;
   localparam int MAX_RUN    = 32;

   typedef enum logic [1:0] {
      ENTRY_FREE  = 2'd0,
      ENTRY_ALLOC = 2'd1,
      ENTRY_ARMED = 2'd2
   } entry_state_type;

   typedef struct packed {
      reply_type         kind;
      logic [4:0]        index;
      logic              ok;
      logic [3:0]        queue;
      logic [31:0]       data;
      logic              last;
   } reply_struct;

   entry_state_type         timer_state [NUM_TIMERS];
   logic [31:0]             timer_deadline [NUM_TIMERS];
   logic [3:0]              timer_queue [NUM_TIMERS];
   logic [31:0]             timer_value [NUM_TIMERS];
   logic [4:0]              timer_next [NUM_TIMERS];
   logic [4:0]              head_index;
   logic [31:0]             now_ticks;
   logic [31:0]             next_due;
   reply_struct             expected_replies [$];

   assign pending_count = expected_replies.size();

   function automatic reply_struct make_reply(reply_type kind, logic [4:0] index, logic ok,
                                              logic [3:0] queue, logic [31:0] data,
                                              logic last);
      reply_struct r;
      r.kind = kind;
      r.index = index;
      r.ok = ok;
      r.queue = queue;
      r.data = data;
      r.last = last;
      return r;
   endfunction

   task automatic clear_table();
      for (int i = 0; i < NUM_TIMERS; i++) begin
         timer_state[i] = ENTRY_FREE;
         timer_deadline[i] = '0;
         timer_queue[i] = '0;
         timer_value[i] = '0;
         timer_next[i] = '0;
      end
      timer_state[0] = ENTRY_ALLOC;
      timer_deadline[0] = DEADLINE_NEVER;
      head_index = '0;
      now_ticks = '0;
      next_due = DEADLINE_NEVER;
      expected_replies.delete();
   endtask

   task automatic insert_timer(logic [4:0] t, logic [31:0] delay);
      logic [31:0] due;
      logic [4:0]  prev;
      logic [4:0]  nxt;
      due = now_ticks + delay;
      timer_deadline[t] = due;
      timer_state[t] = ENTRY_ARMED;
      if (due <= timer_deadline[head_index]) begin
         timer_next[t] = head_index;
         head_index = t;
         next_due = due;
         return;
      end
      prev = head_index;
      for (int g = 0; g < NUM_TIMERS; g++) begin
         nxt = timer_next[prev];
         if (nxt == 0 || due <= timer_deadline[nxt]) begin
            timer_next[prev] = t;
            timer_next[t] = nxt;
            return;
         end
         prev = nxt;
      end
   endtask

   task automatic predict_request(logic [2:0] mode, logic [4:0] t, logic [3:0] q,
                                  logic [31:0] value, logic [31:0] delay);
      logic        usable;
      int          n;
      logic [4:0]  h;
      logic        found;
      usable = (t != 0);
      found = 1'b0;
      n = 0;
      case (mode)
         MODE_TICK: begin
            now_ticks = now_ticks + 1;
            if (next_due <= now_ticks) begin
               while (n < MAX_RUN && head_index != 0 &&
                      timer_deadline[head_index] <= now_ticks) begin
                  h = head_index;
                  timer_state[h] = ENTRY_ALLOC;
                  expected_replies.push_back(make_reply(KIND_EXPIRY, h, 1'b0, timer_queue[h],
                                                        timer_value[h], 1'b0));
                  n++;
                  head_index = timer_next[h];
               end
               next_due = timer_deadline[head_index];
               if (n > 0) expected_replies[expected_replies.size()-1].last = 1'b1;
            end
         end
         MODE_ALLOC: begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (!found && timer_state[i] == ENTRY_FREE) begin
                  timer_state[i] = ENTRY_ALLOC;
                  expected_replies.push_back(make_reply(KIND_ALLOC, 5'(i), 1'b1, '0, '0, 1'b1));
                  found = 1'b1;
               end
            end
            if (!found)
               expected_replies.push_back(make_reply(KIND_ALLOC, '0, 1'b0, '0, '0, 1'b1));
         end
         default: begin
            if (mode == MODE_FREE && usable && timer_state[t] != ENTRY_ARMED)
               timer_state[t] = ENTRY_FREE;
            if (mode == MODE_BIND && usable) begin
               timer_queue[t] = q;
               timer_value[t] = value;
            end
            if (mode == MODE_ARM && usable && timer_state[t] != ENTRY_ARMED)
               insert_timer(t, delay);
            expected_replies.push_back(make_reply(KIND_ACK, '0, 1'b0, '0, '0, 1'b1));
         end
      endcase
   endtask

   always @(posedge clock) begin
      reply_struct seen;
      reply_struct want;
      if (reset) begin
         clear_table();
         error_count <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_request(req_ch.mode, req_ch.timer_index, req_ch.queue_id,
                            req_ch.event_value, req_ch.delay_ticks);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = make_reply(reply_type'(rsp_ch.reply_kind), rsp_ch.entry_index,
                              rsp_ch.alloc_ok, rsp_ch.dest_queue, rsp_ch.expiry_data,
                              rsp_ch.last_of_run);
            if (expected_replies.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: unexpected response %p", $realtime, seen);
               error_count <= error_count + 1;
            end else begin
               want = expected_replies.pop_front();
               if (seen !== want) begin
                  if (error_count < 10)
                     $display("%0t: response mismatch, expected %p, got %p",
                              $realtime, want, seen);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> test/tb_top.sv
// Testbench top for the sorted timer list: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_top;
   import sstl_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset;
   int   error_count;
   int   pending_count;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   quiet_cycles;
   bit   stall_go;
   bit   stall_used;
   int   stall_left;
   bit   bound [32];

   sstl_req_if req_ch ();
   sstl_rsp_if rsp_ch ();

   sorted_software_timer_list DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sstl_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
         stall_used <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_go && !stall_used) begin
         stall_used <= 1'b1;
         stall_left <= 200;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_raw(logic [2:0] mode, logic [4:0] t, logic [3:0] q,
                           logic [31:0] value, logic [31:0] delay);
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.timer_index <= t;
      req_ch.queue_id <= q;
      req_ch.event_value <= value;
      req_ch.delay_ticks <= delay;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (mode == MODE_BIND && t != 0) bound[t] = 1'b1;
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_request(mode_type mode, logic [4:0] t, logic [3:0] q,
                               logic [31:0] value, logic [31:0] delay);
      logic [2:0] raw_mode;
      raw_mode = mode;
      send_raw(raw_mode, t, q, value, delay);
   endtask

   task automatic random_request();
      int          pick;
      logic [4:0]  t;
      logic [31:0] delay;
      pick = $urandom_range(99);
      t = 5'($urandom_range(31));
      if ($urandom_range(3) == 0) delay = $urandom();
      else delay = $urandom_range(12);
      if (pick < 35) begin
         send_request(MODE_TICK, t, 4'($urandom()), $urandom(), $urandom());
      end else if (pick < 45) begin
         send_request(MODE_ALLOC, t, 4'($urandom()), $urandom(), $urandom());
      end else if (pick < 55) begin
         send_request(MODE_FREE, t, 4'($urandom()), $urandom(), $urandom());
      end else if (pick < 67) begin
         send_request(MODE_BIND, t, 4'($urandom()), $urandom(), $urandom());
      end else if (pick < 95) begin
         // An entry must carry a queue and data before it can expire.
         if (t != 0 && !bound[t]) send_request(MODE_BIND, t, 4'($urandom()), $urandom(), delay);
         send_request(MODE_ARM, t, 4'($urandom()), $urandom(), delay);
      end else begin
         send_raw(3'($urandom_range(5, 7)), t, 4'($urandom()), $urandom(), $urandom());
      end
   endtask

   initial begin
      reset = 1'b1;
      stall_go = 1'b0;
      send_idle_pct = 15;
      recv_idle_pct = 53;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_TICK;
      req_ch.timer_index = '0;
      req_ch.queue_id = '0;
      req_ch.event_value = '0;
      req_ch.delay_ticks = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(MODE_ALLOC, 5'd0, 4'd0, 32'd0, 32'd0);
      send_request(MODE_BIND, 5'd1, 4'd15, 32'hffff_ffff, 32'hffff_ffff);
      send_request(MODE_BIND, 5'd2, 4'd0, 32'd0, 32'd0);
      send_request(MODE_BIND, 5'd31, 4'd9, 32'h5a5a_a5a5, 32'd0);
      send_request(MODE_TICK, 5'd31, 4'd15, 32'hffff_ffff, 32'hffff_ffff);
      send_request(MODE_ARM, 5'd1, 4'd0, 32'd0, 32'd0);
      send_request(MODE_TICK, 5'd0, 4'd0, 32'd0, 32'd0);
      send_request(MODE_ARM, 5'd2, 4'd0, 32'd0, 32'hffff_ffff);
      send_request(MODE_ARM, 5'd31, 4'd0, 32'd0, 32'hffff_fff0);
      send_request(MODE_ARM, 5'd1, 4'd0, 32'd0, 32'd1);
      send_request(MODE_FREE, 5'd2, 4'd0, 32'd0, 32'd0);
      send_request(MODE_ARM, 5'd2, 4'd0, 32'd0, 32'd3);
      send_request(MODE_BIND, 5'd0, 4'd7, 32'h1234_5678, 32'd0);
      send_request(MODE_FREE, 5'd0, 4'd0, 32'd0, 32'd0);
      send_request(MODE_ARM, 5'd0, 4'd0, 32'd0, 32'd1);
      send_raw(3'd5, 5'd3, 4'd1, 32'd1, 32'd1);
      send_raw(3'd7, 5'd31, 4'd15, 32'hffff_ffff, 32'hffff_ffff);
      send_request(MODE_TICK, 5'd0, 4'd0, 32'd0, 32'd0);
      send_request(MODE_TICK, 5'd0, 4'd0, 32'd0, 32'd0);
      send_request(MODE_FREE, 5'd1, 4'd0, 32'd0, 32'd0);
      send_request(MODE_FREE, 5'd31, 4'd0, 32'd0, 32'd0);
      repeat (33) send_request(MODE_ALLOC, 5'($urandom()), 4'($urandom()), $urandom(),
                               $urandom());

      repeat (38) random_request();
      send_idle_pct = 53;
      recv_idle_pct = 15;
      repeat (38) random_request();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_go = 1'b1;
      repeat (38) random_request();
      req_ch.valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> sorted_software_timer_list.f
hdl/sstl_pkg.sv
hdl/sstl_if.sv
hdl/sstl_ram.sv
hdl/sstl_flags.sv
hdl/sorted_software_timer_list.sv
test/sstl_checker.sv
test/tb_top.sv
